### hdl/binary_min_heap_queue_unit_defines.svh
// Assertion macros for the binary min-heap queue unit.
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BMHQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmhq check failed");
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmhq check failed");
`else
`define BMHQ_ASSERT_SAME(label, ante, cons)
`define BMHQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/bmhq_pkg.sv
// Shared types, codes and constants of the binary min-heap queue unit.
`default_nettype none

package bmhq_pkg;

  localparam int KEY_W        = 32;
  localparam int INDEX_W      = 10;
  localparam int COUNT_W      = 11;
  localparam int CAPACITY_DEF = 1024;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_MAX = 32'sh7fff_ffff;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DECREASE = 2'd1,
    OP_EXTRACT  = 2'd2,
    OP_SIFT     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_CAPTURE,
    C_CHECK,
    C_INS_BEGIN,
    C_DEC_BEGIN,
    C_EX_READ,
    C_EX_LOAD,
    C_HS_READ,
    C_HS_LOAD,
    C_UP_STEP,
    C_UP_EVAL,
    C_DN_READ,
    C_DN_EVAL,
    C_FINISH
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t code;
    op_t       op;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic root;
    logic up_stop;
    logic dn_stop;
    logic heap_empty;
  } sts_t;

endpackage

`default_nettype wire

### hdl/bmhq_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### hdl/bmhq_dp.sv
// Datapath: key store, occupancy, walk position, held key and result registers.
`default_nettype none

module bmhq_dp #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bmhq_pkg::cmd_t                cmd,
  output bmhq_pkg::sts_t                     sts,
  input  wire logic [bmhq_pkg::KEY_W-1:0]    key_in,
  input  wire logic [bmhq_pkg::INDEX_W-1:0]  index_in,
  output logic      [bmhq_pkg::KEY_W-1:0]    value,
  output logic      [1:0]                    status,
  output logic      [bmhq_pkg::COUNT_W-1:0]  count,
  output logic                               done
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int OW   = $clog2(CAPACITY + 1);
  localparam int CW   = AW + 2;
  localparam int CMPW = (OW > bmhq_pkg::INDEX_W) ? OW : bmhq_pkg::INDEX_W;

  bmhq_pkg::key_t               key_r;
  logic [bmhq_pkg::INDEX_W-1:0] idx_r;
  bmhq_pkg::key_t               hold;
  logic [AW-1:0]                pos;
  logic [OW-1:0]                occ;
  bmhq_pkg::key_t               value_r;
  logic [1:0]                   status_r;

  logic                         we;
  logic [AW-1:0]                waddr;
  bmhq_pkg::key_t               wdata;
  logic [AW-1:0]                raddr_a;
  logic [AW-1:0]                raddr_b;
  logic [bmhq_pkg::KEY_W-1:0]   rdata_a;
  logic [bmhq_pkg::KEY_W-1:0]   rdata_b;
  bmhq_pkg::key_t               ra;
  bmhq_pkg::key_t               rb;

  logic                         full;
  logic                         empty;
  logic                         range_err;
  logic [1:0]                   chk;
  logic [AW-1:0]                parent;
  logic [CW-1:0]                lc;
  logic [CW-1:0]                rc;
  logic                         take_l;
  logic                         take_r;
  bmhq_pkg::key_t               best1;
  bmhq_pkg::key_t               best_val;
  logic [AW-1:0]                best1_idx;
  logic [AW-1:0]                best_idx;
  logic                         up_stop;

  bmhq_ram #(
    .WIDTH (bmhq_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign ra = $signed(rdata_a);
  assign rb = $signed(rdata_b);

  assign full      = (occ >= OW'(CAPACITY));
  assign empty     = (occ == '0);
  assign range_err = (CMPW'(idx_r) >= CMPW'(occ));

  always_comb begin
    chk = bmhq_pkg::ST_OK;
    case (cmd.op)
      bmhq_pkg::OP_INSERT:   if (full) chk = bmhq_pkg::ST_FULL;
      bmhq_pkg::OP_EXTRACT:  if (empty) chk = bmhq_pkg::ST_EMPTY;
      bmhq_pkg::OP_DECREASE: if (range_err) chk = bmhq_pkg::ST_RANGE;
      bmhq_pkg::OP_SIFT:     if (range_err) chk = bmhq_pkg::ST_RANGE;
      default:               chk = bmhq_pkg::ST_OK;
    endcase
  end

  assign parent = (pos - AW'(1)) >> 1;
  assign lc     = {1'b0, pos, 1'b1};
  assign rc     = lc + CW'(1);

  assign up_stop   = (ra <= hold);
  assign take_l    = (lc < CW'(occ)) && (ra < hold);
  assign best1     = take_l ? ra : hold;
  assign best1_idx = take_l ? lc[AW-1:0] : pos;
  assign take_r    = (rc < CW'(occ)) && (rb < best1);
  assign best_val  = take_r ? rb : best1;
  assign best_idx  = take_r ? rc[AW-1:0] : best1_idx;

  assign sts.err        = (chk != bmhq_pkg::ST_OK);
  assign sts.root       = (pos == '0);
  assign sts.up_stop    = up_stop;
  assign sts.dn_stop    = !take_l && !take_r;
  assign sts.heap_empty = empty;

  always_comb begin
    we      = 1'b0;
    waddr   = pos;
    wdata   = hold;
    raddr_a = parent;
    raddr_b = rc[AW-1:0];
    case (cmd.code)
      bmhq_pkg::C_EX_READ: begin
        raddr_a = '0;
        raddr_b = AW'(occ - OW'(1));
      end
      bmhq_pkg::C_HS_READ: begin
        raddr_a = AW'(idx_r);
      end
      bmhq_pkg::C_UP_STEP: begin
        we = sts.root;
      end
      bmhq_pkg::C_UP_EVAL: begin
        we    = 1'b1;
        wdata = up_stop ? hold : ra;
      end
      bmhq_pkg::C_DN_READ: begin
        raddr_a = lc[AW-1:0];
      end
      bmhq_pkg::C_DN_EVAL: begin
        we    = 1'b1;
        wdata = best_val;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cmd.code == bmhq_pkg::C_FINISH);
      case (cmd.code)
        bmhq_pkg::C_CAPTURE: begin
          key_r <= $signed(key_in);
          idx_r <= index_in;
        end
        bmhq_pkg::C_CHECK: begin
          status_r <= chk;
          value_r  <= (chk == bmhq_pkg::ST_EMPTY) ? bmhq_pkg::KEY_MAX : '0;
        end
        bmhq_pkg::C_INS_BEGIN: begin
          hold <= key_r;
          pos  <= AW'(occ);
          occ  <= occ + OW'(1);
        end
        bmhq_pkg::C_DEC_BEGIN: begin
          hold <= key_r;
          pos  <= AW'(idx_r);
        end
        bmhq_pkg::C_EX_READ: begin
          occ <= occ - OW'(1);
        end
        bmhq_pkg::C_EX_LOAD: begin
          value_r <= ra;
          hold    <= rb;
          pos     <= '0;
        end
        bmhq_pkg::C_HS_READ: begin
          pos <= AW'(idx_r);
        end
        bmhq_pkg::C_HS_LOAD: begin
          hold <= ra;
        end
        bmhq_pkg::C_UP_EVAL: begin
          if (!up_stop) pos <= parent;
        end
        bmhq_pkg::C_DN_EVAL: begin
          pos <= best_idx;
        end
        bmhq_pkg::C_FINISH: begin
          value  <= value_r;
          status <= status_r;
          count  <= bmhq_pkg::COUNT_W'(occ);
        end
        default: begin
          pos <= pos;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bmhq_ctrl.sv
// Controller: sequences checks, heap walks and the result strobe.
`default_nettype none

module bmhq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     op,
  output logic                busy,
  output bmhq_pkg::cmd_t      cmd,
  input  wire bmhq_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_BEGIN,
    S_EX_RD,
    S_EX_LD,
    S_HS_RD,
    S_HS_LD,
    S_UP_RD,
    S_UP_EV,
    S_DN_RD,
    S_DN_EV,
    S_RESULT
  } state_t;

  state_t        state;
  state_t        state_next;
  bmhq_pkg::op_t op_r;

  always_comb begin
    state_next = state;
    cmd.code   = bmhq_pkg::C_IDLE;
    cmd.op     = op_r;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.code   = bmhq_pkg::C_CAPTURE;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.code = bmhq_pkg::C_CHECK;
        if (sts.err) begin
          state_next = S_RESULT;
        end else if (op_r inside {bmhq_pkg::OP_INSERT, bmhq_pkg::OP_DECREASE}) begin
          state_next = S_BEGIN;
        end else if (op_r == bmhq_pkg::OP_EXTRACT) begin
          state_next = S_EX_RD;
        end else begin
          state_next = S_HS_RD;
        end
      end
      S_BEGIN: begin
        cmd.code = (op_r == bmhq_pkg::OP_INSERT) ? bmhq_pkg::C_INS_BEGIN
                                                 : bmhq_pkg::C_DEC_BEGIN;
        state_next = S_UP_RD;
      end
      S_EX_RD: begin
        cmd.code   = bmhq_pkg::C_EX_READ;
        state_next = S_EX_LD;
      end
      S_EX_LD: begin
        cmd.code   = bmhq_pkg::C_EX_LOAD;
        state_next = sts.heap_empty ? S_RESULT : S_DN_RD;
      end
      S_HS_RD: begin
        cmd.code   = bmhq_pkg::C_HS_READ;
        state_next = S_HS_LD;
      end
      S_HS_LD: begin
        cmd.code   = bmhq_pkg::C_HS_LOAD;
        state_next = S_DN_RD;
      end
      S_UP_RD: begin
        cmd.code   = bmhq_pkg::C_UP_STEP;
        state_next = sts.root ? S_RESULT : S_UP_EV;
      end
      S_UP_EV: begin
        cmd.code   = bmhq_pkg::C_UP_EVAL;
        state_next = sts.up_stop ? S_RESULT : S_UP_RD;
      end
      S_DN_RD: begin
        cmd.code   = bmhq_pkg::C_DN_READ;
        state_next = S_DN_EV;
      end
      S_DN_EV: begin
        cmd.code   = bmhq_pkg::C_DN_EVAL;
        state_next = sts.dn_stop ? S_RESULT : S_DN_RD;
      end
      S_RESULT: begin
        cmd.code   = bmhq_pkg::C_FINISH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      op_r  <= bmhq_pkg::OP_INSERT;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      if (state == S_IDLE && start) begin
        op_r <= bmhq_pkg::op_t'(op);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue of signed keys: top level and checks.
// A rejected request goes from the check straight to the result strobe; an accepted one
// walks the key up or down the heap, one level at a time, before the result strobe.
// Each level costs a registered RAM read and a write of the key store port.
// A new request is taken in the cycle the done strobe is shown; results cannot stall.
// Reset (rst, synchronous) empties the heap; key store contents are not cleared.
`default_nettype none

`include "binary_min_heap_queue_unit_defines.svh"

module binary_min_heap_queue_unit #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    op,
  input  wire logic [bmhq_pkg::KEY_W-1:0]    key,
  input  wire logic [bmhq_pkg::INDEX_W-1:0]  index,
  output logic                               done,
  output logic      [bmhq_pkg::KEY_W-1:0]    value,
  output logic      [1:0]                    status,
  output logic      [bmhq_pkg::COUNT_W-1:0]  count
);

  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .key_in   (key),
    .index_in (index),
    .value    (value),
    .status   (status),
    .count    (count),
    .done     (done)
  );

  `BMHQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `BMHQ_ASSERT_SAME(a_done_idle, done, !busy)
  `BMHQ_ASSERT_SAME(a_full_count, done && status == bmhq_pkg::ST_FULL,
                    count == bmhq_pkg::COUNT_W'(CAPACITY))
  `BMHQ_ASSERT_SAME(a_empty_result, done && status == bmhq_pkg::ST_EMPTY,
                    value == bmhq_pkg::KEY_MAX && count == '0)

endmodule

`default_nettype wire

### sim/tb_binary_min_heap_queue_unit.sv
// Testbench for the binary min-heap queue unit: random and directed requests, scoreboard check.
module tb_binary_min_heap_queue_unit;
  import bmhq_pkg::*;

  localparam int HEAP_CAP = CAPACITY_DEF;

  typedef struct {
    key_t         value;
    logic [1:0]   status;
    logic [10:0]  count;
  } heap_result_t;

  class heap_scoreboard;
    key_t         slots[HEAP_CAP];
    int unsigned  fill;
    heap_result_t awaited[$];
    int           mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      key_t t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void sift_up(int unsigned pos);
      int unsigned parent;
      while (pos != 0) begin
        parent = (pos - 1) / 2;
        if (slots[parent] <= slots[pos]) break;
        swap_slots(pos, parent);
        pos = parent;
      end
    endfunction

    function void sift_down(int unsigned pos);
      int unsigned l;
      int unsigned r;
      int unsigned best;
      forever begin
        l = 2 * pos + 1;
        r = l + 1;
        best = pos;
        if (l < fill && slots[l] < slots[best]) best = l;
        if (r < fill && slots[r] < slots[best]) best = r;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    endfunction

    // Apply one accepted request to the shadow heap and queue its result.
    function void note_request(op_t req_op, key_t req_key, logic [INDEX_W-1:0] req_index);
      heap_result_t res;
      res.value = '0;
      res.status = ST_OK;
      case (req_op)
        OP_INSERT: begin
          if (fill >= HEAP_CAP) begin
            res.status = ST_FULL;
          end else begin
            slots[fill] = req_key;
            fill++;
            sift_up(fill - 1);
          end
        end
        OP_DECREASE: begin
          if (req_index >= fill) begin
            res.status = ST_RANGE;
          end else begin
            slots[req_index] = req_key;
            sift_up(req_index);
          end
        end
        OP_EXTRACT: begin
          if (fill == 0) begin
            res.value = KEY_MAX;
            res.status = ST_EMPTY;
          end else begin
            res.value = slots[0];
            fill--;
            if (fill > 0) begin
              slots[0] = slots[fill];
              sift_down(0);
            end
          end
        end
        default: begin
          if (req_index >= fill) res.status = ST_RANGE;
          else sift_down(req_index);
        end
      endcase
      res.count = fill[10:0];
      awaited.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(key_t got_value, logic [1:0] got_status, logic [10:0] got_count);
      heap_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d count %0d",
                                  got_value, got_status, got_count));
        return;
      end
      want = awaited.pop_front();
      if (got_value !== want.value)
        report_mismatch($sformatf("value %0d, want %0d", got_value, want.value));
      if (got_status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
      if (got_count !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", got_count, want.count));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           op = OP_INSERT;
  logic [KEY_W-1:0]     key = '0;
  logic [INDEX_W-1:0]   index = '0;
  logic                 busy;
  logic                 done;
  logic [KEY_W-1:0]     value;
  logic [1:0]           status;
  logic [COUNT_W-1:0]   count;

  heap_scoreboard sb = new();
  bit no_idle = 1'b0;

  binary_min_heap_queue_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .key    (key),
    .index  (index),
    .done   (done),
    .value  (value),
    .status (status),
    .count  (count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(value, status, count);
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return KEY_MAX;
      1: return 32'sh8000_0000;
      2, 3, 4: return key_t'($signed($urandom_range(0, 16)) - 8);
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8 && sb.fill > 0) return INDEX_W'($urandom_range(0, sb.fill - 1));
    if (r == 8 && sb.fill < HEAP_CAP) return INDEX_W'($urandom_range(sb.fill, HEAP_CAP - 1));
    return INDEX_W'($urandom_range(0, HEAP_CAP - 1));
  endfunction

  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_request(op_t req_op, key_t req_key, logic [INDEX_W-1:0] req_index);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op    <= req_op;
    key   <= req_key;
    index <= req_index;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(req_op, req_key, req_index);
  endtask

  task automatic issue_random(int ins_w, int dec_w, int ext_w);
    int r;
    logic [INDEX_W-1:0] ix;
    key_t k;
    r = $urandom_range(0, 99);
    ix = pick_index();
    k = pick_key();
    if (r < ins_w) begin
      send_request(OP_INSERT, k, INDEX_W'($urandom));
    end else if (r < ins_w + dec_w) begin
      if ($urandom_range(0, 1) == 1 && ix < sb.fill)
        k = sb.slots[ix] - key_t'($urandom_range(0, 1000));
      send_request(OP_DECREASE, k, ix);
    end else if (r < ins_w + dec_w + ext_w) begin
      send_request(OP_EXTRACT, key_t'($urandom), INDEX_W'($urandom));
    end else begin
      send_request(OP_SIFT, key_t'($urandom), ix);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty heap, extremes, ties, boundaries
    send_request(OP_EXTRACT, 32'sh0, 10'h3ff);
    send_request(OP_DECREASE, 32'sh1, 10'h0);
    send_request(OP_SIFT, 32'sh0, 10'h0);
    send_request(OP_INSERT, KEY_MAX, 10'h0);
    send_request(OP_INSERT, 32'sh8000_0000, 10'h3ff);
    send_request(OP_INSERT, 32'sh0, 10'h0);
    send_request(OP_INSERT, -32'sh1, 10'h0);
    send_request(OP_INSERT, 32'sh1, 10'h0);
    send_request(OP_INSERT, 32'sh0, 10'h0);
    send_request(OP_DECREASE, 32'sh8000_0000, INDEX_W'(sb.fill - 1));
    send_request(OP_DECREASE, KEY_MAX, 10'h0);
    send_request(OP_SIFT, 32'sh0, 10'h0);
    send_request(OP_SIFT, 32'sh0, INDEX_W'(sb.fill - 1));
    send_request(OP_DECREASE, 32'sh5, INDEX_W'(sb.fill));
    send_request(OP_SIFT, 32'sh0, 10'h3ff);
    send_request(OP_INSERT, 32'sh5555_5555, 10'h2aa);
    send_request(OP_INSERT, 32'shaaaa_aaaa, 10'h155);
    while (sb.fill > 0) send_request(OP_EXTRACT, 32'sh0, 10'h0);
    send_request(OP_EXTRACT, 32'sh7fff_ffff, 10'h0);

    repeat (250) issue_random(35, 20, 30);

    // grow to capacity, then work around the full boundary
    while (sb.fill < HEAP_CAP) issue_random(88, 4, 4);
    repeat (4) send_request(OP_INSERT, pick_key(), INDEX_W'($urandom));
    send_request(OP_DECREASE, 32'sh8000_0000, 10'h3ff);
    send_request(OP_SIFT, 32'sh0, 10'h3ff);
    send_request(OP_SIFT, 32'sh0, 10'h0);
    repeat (80) issue_random(45, 20, 15);

    repeat (250) issue_random(10, 15, 60);

    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #12000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
